[hdl/smf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants for the segment morph frame engine
// Field widths, register indexes, sequencer states, divider command and
// frame helpers used by the bit-serial units and the top level.
// ----------------------------------------------------------------------------
package smf_pkg;

   localparam int MAX_DIGITS = 8;
   localparam int FRAME_W    = 64;
   localparam int DCNT_W     = 4;
   localparam int DUR_W      = 32;
   localparam int STEPS_W    = 16;
   localparam int ELAPSED_W  = 32;
   localparam int PROD_W     = ELAPSED_W + STEPS_W;
   localparam int THR_W      = 8;
   localparam int TOTAL_W    = 7;    // digits * 8, up to 64
   localparam int LIMIT_W    = 14;   // (threshold + 1) * total, up to 16320
   localparam int DIV_CNT_W  = 5;
   localparam int CSR_IDX_W  = 3;

   localparam logic [DIV_CNT_W-1:0] DIV_STEP_ITERS = DIV_CNT_W'(STEPS_W);
   localparam logic [DIV_CNT_W-1:0] DIV_THR_ITERS  = DIV_CNT_W'(THR_W);

   localparam logic [CSR_IDX_W-1:0] CSR_DIGITS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MORPH_STEPS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_SEGS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SEGS = 3'd4;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam int RSP_UPDATED_BIT = 0;
   localparam int RSP_DONE_BIT    = 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV1,
      ST_CHECK,
      ST_DIV2,
      ST_BLEND,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DUR_W-1:0]     rem_init;
      logic [STEPS_W-1:0]   num_lo;
      logic [DUR_W-1:0]     divisor;
      logic [DIV_CNT_W-1:0] iters;
   } div_cmd_type;

   // clamp the digit count to the display size
   function automatic logic [DCNT_W-1:0] digits_in_use(input logic [DCNT_W-1:0] cnt);
      logic [DCNT_W-1:0] n;
      n = cnt;
      if (cnt > DCNT_W'(MAX_DIGITS)) begin
         n = DCNT_W'(MAX_DIGITS);
      end
      return n;
   endfunction

   // one byte of ones for every digit in use
   function automatic logic [FRAME_W-1:0] frame_mask(input logic [DCNT_W-1:0] n);
      logic [FRAME_W-1:0] m;
      m = '0;
      for (int d = 0; d < MAX_DIGITS; d++) begin
         m[8*d +: 8] = (DCNT_W'(d) < n) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

[hdl/smf_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_mul: bit-serial multiplier
// Shift-add product of elapsed time and step count, one multiplier bit per
// cycle, most significant bit first.
// ----------------------------------------------------------------------------
module smf_mul
   import smf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [ELAPSED_W-1:0] a,
   input  wire logic [STEPS_W-1:0]   b,
   output logic                      done,
   output logic [PROD_W-1:0]         product
);

   localparam logic [3:0] LAST_BIT = 4'(STEPS_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [ELAPSED_W-1:0] a_ff, a_in;
   logic [STEPS_W-1:0]   b_ff, b_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = {acc_ff[PROD_W-2:0], 1'b0}
                  + (b_ff[STEPS_W-1] ? {{STEPS_W{1'b0}}, a_ff} : '0);
         b_in   = {b_ff[STEPS_W-2:0], 1'b0};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == LAST_BIT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
`default_nettype wire

[hdl/smf_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_div: bit-serial restoring divider
// One quotient bit per cycle. The caller loads a partial remainder that is
// already below the divisor, so the quotient fits the iteration count.
// ----------------------------------------------------------------------------
module smf_div
   import smf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire div_cmd_type        cmd,
   output logic                    done,
   output logic [STEPS_W-1:0]      quot
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DUR_W-1:0]     rem_ff, rem_in;
   logic [STEPS_W-1:0]   lo_ff, lo_in;
   logic [STEPS_W-1:0]   q_ff, q_in;
   logic [DUR_W-1:0]     div_ff, div_in;
   logic [DUR_W:0]       trial;
   logic [DUR_W:0]       diff;
   logic                 ge;

   always_comb begin
      trial = {rem_ff, lo_ff[STEPS_W-1]};
      diff  = trial - {1'b0, div_ff};
      ge    = (trial >= {1'b0, div_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      div_in  = div_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.iters;
         rem_in  = cmd.rem_init;
         lo_in   = cmd.num_lo;
         q_in    = '0;
         div_in  = cmd.divisor;
      end else if (busy_ff) begin
         // keep the remainder when the trial falls short, subtract otherwise
         rem_in = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
         lo_in  = {lo_ff[STEPS_W-2:0], 1'b0};
         q_in   = {q_ff[STEPS_W-2:0], ge};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
`default_nettype wire

[hdl/smf_blend.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_blend: bit-serial frame blender
// Walks the 64 segment positions one per cycle. A running pos*255 sum is
// compared to (threshold+1)*total to pick the target or the start bit.
// ----------------------------------------------------------------------------
module smf_blend
   import smf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [LIMIT_W-1:0] limit,
   input  wire logic [TOTAL_W-1:0] total,
   input  wire logic [FRAME_W-1:0] start_seg,
   input  wire logic [FRAME_W-1:0] target_seg,
   output logic                    done,
   output logic [FRAME_W-1:0]      frame
);

   localparam logic [TOTAL_W-1:0] LAST_POS = TOTAL_W'(FRAME_W - 1);
   localparam logic [LIMIT_W-1:0] WEIGHT_STEP = LIMIT_W'(255);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [TOTAL_W-1:0]   pos_ff, pos_in;
   logic [LIMIT_W-1:0]   acc_ff, acc_in;
   logic [LIMIT_W-1:0]   lim_ff, lim_in;
   logic [TOTAL_W-1:0]   tot_ff, tot_in;
   logic [FRAME_W-1:0]   st_ff, st_in;
   logic [FRAME_W-1:0]   tg_ff, tg_in;
   logic [FRAME_W-1:0]   fr_ff, fr_in;
   logic                 bit_out;

   always_comb begin
      // positions past the digits in use stay dark
      bit_out = (pos_ff < tot_ff) && ((acc_ff < lim_ff) ? tg_ff[0] : st_ff[0]);

      busy_in = busy_ff;
      done_in = 1'b0;
      pos_in  = pos_ff;
      acc_in  = acc_ff;
      lim_in  = lim_ff;
      tot_in  = tot_ff;
      st_in   = st_ff;
      tg_in   = tg_ff;
      fr_in   = fr_ff;
      if (start) begin
         busy_in = 1'b1;
         pos_in  = '0;
         acc_in  = '0;
         lim_in  = limit;
         tot_in  = total;
         st_in   = start_seg;
         tg_in   = target_seg;
      end else if (busy_ff) begin
         fr_in  = {bit_out, fr_ff[FRAME_W-1:1]};
         st_in  = {1'b0, st_ff[FRAME_W-1:1]};
         tg_in  = {1'b0, tg_ff[FRAME_W-1:1]};
         acc_in = acc_ff + WEIGHT_STEP;
         pos_in = pos_ff + TOTAL_W'(1);
         if (pos_ff == LAST_POS) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      acc_ff <= acc_in;
      lim_ff <= lim_in;
      tot_ff <= tot_in;
      st_ff  <= st_in;
      tg_ff  <= tg_in;
      fr_ff  <= fr_in;
   end

   assign done  = done_ff;
   assign frame = fr_ff;

endmodule
`default_nettype wire

[hdl/segment_morph_frame_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_morph_frame_engine: start-to-target segment frame morph
// Turns start and tick beats into frame updates. Step and threshold come
// from a bit-serial multiplier and a shared bit-serial divider; the frame is
// built one segment position per cycle.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  -------  ---------  --------------------------------------------------
//  req_     in         tuser[0] op, tdata[31:0] elapsed
//  rsp_     out        tuser[0] updated, tuser[1] done_res, tdata frame
//  csr_     in         we, index (0..4), wdata[63:0], write-only
//
//  Start beats, ticks while idle, finishing ticks and ticks with no steps
//  set load their result beat at the accepting edge; it shows the next cycle.
//  A tick that reaches the step check runs the serial multiply and the
//  serial step divide; when the step changes it also runs the serial
//  threshold divide and the blend walk, and its result is loaded only once
//  the last of them is done. The input stays closed.
//  Synchronous active-high reset returns the configuration registers to
//  their defaults and the morph to idle. A stalled result holds in the
//  output register; the next beat is taken in that same cycle it drains.
// ----------------------------------------------------------------------------
module segment_morph_frame_engine
   import smf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request stream
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          req_tdata,   // [31:0] elapsed
   input  wire logic [0:0]           req_tuser,   // [0] op
   // response stream
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [63:0]               rsp_tdata,   // [63:0] frame
   output logic [1:0]                rsp_tuser,   // [0] updated, [1] done_res
   // configuration writes
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]          csr_wdata
);

   // configuration registers
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;
   logic [DUR_W-1:0]   dur_ff, dur_in;
   logic [STEPS_W-1:0] steps_ff, steps_in;
   logic [FRAME_W-1:0] sseg_ff, sseg_in;
   logic [FRAME_W-1:0] tseg_ff, tseg_in;

   // morph state and sequencer
   state_type          state_ff, state_in;
   logic               active_ff, active_in;
   logic [STEPS_W-1:0] last_step_ff, last_step_in;
   logic [STEPS_W-1:0] step_ff, step_in;
   logic               pend_upd_ff, pend_upd_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;
   logic [FRAME_W-1:0] rsp_data_ff, rsp_data_in;

   // serial unit hookup
   logic                 mul_start;
   logic                 mul_done;
   logic [PROD_W-1:0]    mul_product;
   div_cmd_type          div_cmd;
   logic                 div_done;
   logic [STEPS_W-1:0]   div_quot;
   logic                 blend_start;
   logic                 blend_done;
   logic [FRAME_W-1:0]   blend_frame;

   logic                 out_free;
   logic                 req_fire;
   logic                 op;
   logic [ELAPSED_W-1:0] elapsed;
   logic [DCNT_W-1:0]    n_digits;
   logic [TOTAL_W-1:0]   total;
   logic [23:0]          step_x255;
   logic [THR_W:0]       thr_p1;
   logic [LIMIT_W-1:0]   limit_full;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign op         = req_tuser[0];
   assign elapsed    = req_tdata[ELAPSED_W-1:0];

   assign n_digits   = digits_in_use(dcnt_ff);
   assign total      = {n_digits, 3'b000};
   // step*255 as (step << 8) - step
   assign step_x255  = {step_ff, 8'h00} - {8'h00, step_ff};
   // threshold >= floor(pos*255/total) exactly when pos*255 < (threshold+1)*total;
   // threshold stays below 255, so the product fits the limit width
   assign thr_p1     = {1'b0, div_quot[THR_W-1:0]} + (THR_W+1)'(1);
   assign limit_full = {{(LIMIT_W-THR_W-1){1'b0}}, thr_p1}
                       * {{(LIMIT_W-TOTAL_W){1'b0}}, total};

   // configuration port: writes beyond the register list drop
   always_comb begin
      dcnt_in  = dcnt_ff;
      dur_in   = dur_ff;
      steps_in = steps_ff;
      sseg_in  = sseg_ff;
      tseg_in  = tseg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DIGITS:      dcnt_in  = csr_wdata[DCNT_W-1:0];
            CSR_DURATION:    dur_in   = csr_wdata[DUR_W-1:0];
            CSR_MORPH_STEPS: steps_in = csr_wdata[STEPS_W-1:0];
            CSR_START_SEGS:  sseg_in  = csr_wdata;
            CSR_TARGET_SEGS: tseg_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      last_step_in = last_step_ff;
      step_in      = step_ff;
      pend_upd_in  = pend_upd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      div_cmd      = '0;
      blend_start  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // default answer: no update
               rsp_valid_in = 1'b1;
               rsp_user_in  = '0;
               rsp_data_in  = '0;
               if (op == OP_START) begin
                  if (!active_ff && (dur_ff != '0) && (steps_ff != '0)) begin
                     active_in    = 1'b1;
                     last_step_in = '0;
                  end
               end else if (active_ff) begin
                  if (elapsed >= dur_ff) begin
                     // finish: show the target and drop to idle
                     active_in                    = 1'b0;
                     rsp_user_in[RSP_UPDATED_BIT] = 1'b1;
                     rsp_user_in[RSP_DONE_BIT]    = 1'b1;
                     rsp_data_in                  = tseg_ff & frame_mask(n_digits);
                  end else if (steps_ff != '0) begin
                     // hold the result back until the step check and any frame build are done
                     rsp_valid_in = 1'b0;
                     mul_start    = 1'b1;
                     state_in     = ST_MUL;
                  end
               end
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               div_cmd.start    = 1'b1;
               div_cmd.rem_init = mul_product[PROD_W-1:STEPS_W];
               div_cmd.num_lo   = mul_product[STEPS_W-1:0];
               div_cmd.divisor  = dur_ff;
               div_cmd.iters    = DIV_STEP_ITERS;
               state_in         = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               step_in  = div_quot;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (step_ff == last_step_ff) begin
               pend_upd_in = 1'b0;
               state_in    = ST_EMIT;
            end else begin
               last_step_in     = step_ff;
               div_cmd.start    = 1'b1;
               div_cmd.rem_init = {16'h0000, step_x255[23:8]};
               div_cmd.num_lo   = {step_x255[7:0], 8'h00};
               div_cmd.divisor  = {16'h0000, steps_ff};
               div_cmd.iters    = DIV_THR_ITERS;
               state_in         = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_done) begin
               blend_start = 1'b1;
               state_in    = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (blend_done) begin
               pend_upd_in = 1'b1;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_user_in                  = '0;
               rsp_user_in[RSP_UPDATED_BIT] = pend_upd_ff;
               rsp_data_in                  = pend_upd_ff ? blend_frame : '0;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff      <= DCNT_W'(8);
         dur_ff       <= DUR_W'(1000);
         steps_ff     <= STEPS_W'(16);
         sseg_ff      <= '0;
         tseg_ff      <= '0;
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         last_step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dcnt_ff      <= dcnt_in;
         dur_ff       <= dur_in;
         steps_ff     <= steps_in;
         sseg_ff      <= sseg_in;
         tseg_ff      <= tseg_in;
         state_ff     <= state_in;
         active_ff    <= active_in;
         last_step_ff <= last_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      pend_upd_ff <= pend_upd_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   smf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (elapsed),
      .b       (steps_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   smf_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .done  (div_done),
      .quot  (div_quot)
   );

   smf_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .start      (blend_start),
      .limit      (limit_full),
      .total      (total),
      .start_seg  (sseg_ff),
      .target_seg (tseg_ff),
      .done       (blend_done),
      .frame      (blend_frame)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a finishing beat always leaves the morph idle while it waits
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[RSP_DONE_BIT]) |-> !active_ff)
      else $error("done result while morph still active");

   // the morph arms only on an accepted start beat
   a_arm_on_start: assert property (@(posedge clock) disable iff (reset)
      $rose(active_ff) |-> $past(req_fire && (op == OP_START)))
      else $error("morph armed without a start beat");

   // serial units report completion only in the state waiting for them
   a_mul_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL))
      else $error("multiplier done outside its state");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == ST_DIV1) || (state_ff == ST_DIV2)))
      else $error("divider done outside its states");

   a_blend_state: assert property (@(posedge clock) disable iff (reset)
      blend_done |-> (state_ff == ST_BLEND))
      else $error("blend done outside its state");

endmodule
`default_nettype wire
